// ===== hw/rtl/rtss_pkg.sv =====
// Package for the record table block: payload structs, operation and status codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rtss_pkg;
   localparam int Depth = 32;
   localparam int IdxW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam int QDepth = 2;
   localparam int QPtrW = $clog2(QDepth);
   localparam int QCntW = $clog2(QDepth + 1);

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_SORT = 3'd4;
   localparam logic [2:0] OP_LIST = 3'd5;

   localparam logic [2:0] ST_RECORD = 3'd0;
   localparam logic [2:0] ST_DONE = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_FEW = 3'd4;

   typedef struct packed {
      logic [7:0] building;
      logic [15:0] room;
      logic [15:0] area;
      logic [7:0] capacity;
      logic [7:0] occupants;
   } rec_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [15:0] key_room;
      logic [7:0] new_building;
      logic [15:0] new_room;
      logic [15:0] new_area;
      logic [7:0] new_capacity;
      logic [7:0] new_occupants;
   } req_type;

   typedef struct packed {
      logic [7:0] out_building;
      logic [15:0] out_room;
      logic [15:0] out_area;
      logic [7:0] out_capacity;
      logic [7:0] out_occupants;
      logic [2:0] status;
      logic last;
   } rsp_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic [2:0] op;
      logic [15:0] key;
      rec_type rec;
   } cmd_type;

   // Queue handshake between front and back.
   typedef struct packed {
      logic valid;
   } qctl_type;
endpackage
`default_nettype wire

// ===== hw/rtl/rtss_front.sv =====
// Front end: takes command words, drops undefined codes, queues the rest unless full.
// Depends on rtss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtss_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire rtss_pkg::req_type req_data,
   output logic busy,
   output rtss_pkg::cmd_type cmd,
   output rtss_pkg::qctl_type qctl_out,
   input  wire logic back_ready
);
   rtss_pkg::cmd_type q_ff [rtss_pkg::QDepth];
   logic [rtss_pkg::QPtrW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [rtss_pkg::QCntW-1:0] cnt_ff, cnt_in;
   logic push, pop, legal;

   // Only defined operation codes enter the queue.
   assign legal = req_data.operation <= rtss_pkg::OP_LIST;
   assign busy = cnt_ff == rtss_pkg::QCntW'(rtss_pkg::QDepth);
   assign push = start && !busy && legal;
   assign pop = qctl_out.valid && back_ready;
   assign qctl_out.valid = cnt_ff != '0;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      rd_in = rd_ff + rtss_pkg::QPtrW'(pop);
      wr_in = wr_ff + rtss_pkg::QPtrW'(push);
      cnt_in = cnt_ff + rtss_pkg::QCntW'(push) - rtss_pkg::QCntW'(pop);
   end

   // Queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{op: req_data.operation, key: req_data.key_room,
            rec: '{req_data.new_building, req_data.new_room, req_data.new_area,
                   req_data.new_capacity, req_data.new_occupants}};
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rtss_pkg::QCntW'(rtss_pkg::QDepth)) else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
endmodule
`default_nettype wire

// ===== hw/rtl/rtss_back.sv =====
// Back end: executes table commands over the record memory, one command at a time.
// Depends on rtss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtss_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire rtss_pkg::cmd_type cmd,
   input  wire rtss_pkg::qctl_type qctl_in,
   output logic back_ready,
   output logic rsp_strobe,
   output rtss_pkg::rsp_type rsp_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD = 3'd1;
   localparam logic [2:0] S_EX = 3'd2;
   localparam logic [2:0] S_SRD = 3'd3;
   localparam logic [2:0] S_SA = 3'd4;
   localparam logic [2:0] S_SEX = 3'd5;
   localparam logic [2:0] S_FIN = 3'd6;
   localparam logic [2:0] S_TL = 3'd7;

   localparam int IW = rtss_pkg::IdxW;
   localparam int CW = rtss_pkg::CntW;

   rtss_pkg::rec_type mem [rtss_pkg::Depth];
   rtss_pkg::rec_type rdat_ff, hold_ff, hold_in;
   rtss_pkg::cmd_type c_ff, c_in;
   logic [2:0] st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, lim_ff, lim_in;
   logic [IW-1:0] ra;
   logic re;
   logic [IW-1:0] wa;
   logic we;
   rtss_pkg::rec_type wd;
   logic hit_ff, hit_in;
   logic pend_ff, pend_in;
   rtss_pkg::rec_type pend_rec_ff, pend_rec_in;
   logic o_v_ff, o_v_in;
   rtss_pkg::rsp_type o_ff, o_in;

   assign back_ready = st_ff == S_IDLE;
   assign rsp_strobe = o_v_ff;
   assign rsp_data = o_ff;

   function automatic rtss_pkg::rsp_type mk_rec(rtss_pkg::rec_type r, logic lst);
      return '{r.building, r.room, r.area, r.capacity, r.occupants,
               rtss_pkg::ST_RECORD, lst};
   endfunction
   function automatic rtss_pkg::rsp_type mk_st(logic [2:0] s);
      return '{8'd0, 16'd0, 16'd0, 8'd0, 8'd0, s, 1'b1};
   endfunction

   // Record memory with a registered read port.
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (re) rdat_ff <= mem[ra];
   end

   // Sequencer: a walk over the table; a sort step may read one entry while writing another.
   always_comb begin
      st_in = st_ff; c_in = c_ff; cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff;
      lim_in = lim_ff; hit_in = hit_ff; hold_in = hold_ff;
      pend_in = pend_ff; pend_rec_in = pend_rec_ff;
      o_v_in = 1'b0; o_in = o_ff;
      re = 1'b0; ra = i_ff[IW-1:0]; we = 1'b0; wa = i_ff[IW-1:0]; wd = c_ff.rec;
      unique case (st_ff)
         S_IDLE: begin
            if (qctl_in.valid) begin
               c_in = cmd; i_in = '0; j_in = '0; hit_in = 1'b0; pend_in = 1'b0;
               priority if (cmd.op == rtss_pkg::OP_INSERT) begin
                  o_v_in = 1'b1;
                  if (cnt_ff < CW'(rtss_pkg::Depth)) begin
                     we = 1'b1; wa = cnt_ff[IW-1:0]; wd = cmd.rec;
                     cnt_in = cnt_ff + 1'b1;
                     o_in = mk_st(rtss_pkg::ST_DONE);
                  end else o_in = mk_st(rtss_pkg::ST_FULL);
               end else if (cmd.op == rtss_pkg::OP_SORT) begin
                  if (cnt_ff < CW'(2)) begin
                     o_v_in = 1'b1; o_in = mk_st(rtss_pkg::ST_FEW);
                  end else begin
                     lim_in = cnt_ff - 1'b1; st_in = S_SRD;
                  end
               end else st_in = S_FIN;
            end
         end
         // Linear walk: issue read of entry i.
         S_RD: begin
            re = 1'b1; st_in = S_EX;
         end
         S_EX: begin
            st_in = S_FIN;
            unique case (c_ff.op)
               rtss_pkg::OP_DELETE: begin
                  if (rdat_ff.room != c_ff.key) begin
                     we = 1'b1; wa = j_ff[IW-1:0]; wd = rdat_ff; j_in = j_ff + 1'b1;
                  end else hit_in = 1'b1;
               end
               rtss_pkg::OP_UPDATE: begin
                  if (rdat_ff.room == c_ff.key) begin
                     we = 1'b1;
                     if (pend_ff) begin o_v_in = 1'b1; o_in = mk_rec(pend_rec_ff, 1'b0); end
                     pend_in = 1'b1; pend_rec_in = c_ff.rec;
                  end
               end
               rtss_pkg::OP_SEARCH, rtss_pkg::OP_LIST: begin
                  if (c_ff.op == rtss_pkg::OP_LIST || rdat_ff.room == c_ff.key) begin
                     if (pend_ff) begin o_v_in = 1'b1; o_in = mk_rec(pend_rec_ff, 1'b0); end
                     pend_in = 1'b1; pend_rec_in = rdat_ff;
                  end
               end
               default: ;
            endcase
            i_in = i_ff + 1'b1;
         end
         // Loop head and completion of linear operations.
         S_FIN: begin
            if (i_ff < cnt_ff) st_in = S_RD;
            else begin
               st_in = S_IDLE; o_v_in = 1'b1;
               if (c_ff.op == rtss_pkg::OP_DELETE) begin
                  cnt_in = j_ff;
                  o_in = mk_st(hit_ff ? rtss_pkg::ST_DONE : rtss_pkg::ST_NOTFOUND);
               end else if (pend_ff) o_in = mk_rec(pend_rec_ff, 1'b1);
               else o_in = mk_st(rtss_pkg::ST_NOTFOUND);
            end
         end
         // Bubble pass: j walks 0..lim-1, hold carries the larger record.
         S_SRD: begin
            if (lim_ff == '0) begin
               st_in = S_IDLE; o_v_in = 1'b1; o_in = mk_st(rtss_pkg::ST_DONE);
            end else begin
               re = 1'b1; ra = '0; j_in = '0; st_in = S_SA;
            end
         end
         S_SA: begin
            hold_in = rdat_ff; re = 1'b1; ra = IW'(j_ff + 1'b1); st_in = S_SEX;
         end
         S_SEX: begin
            we = 1'b1; wa = j_ff[IW-1:0];
            if (hold_ff.occupants > rdat_ff.occupants) wd = rdat_ff;
            else begin wd = hold_ff; hold_in = rdat_ff; end
            j_in = j_ff + 1'b1;
            if (j_ff + 1'b1 == lim_ff) begin
               st_in = S_TL;
            end else begin
               re = 1'b1; ra = IW'(j_ff + 2'd2);
            end
         end
         // End of a pass: the larger record settles at the top of the pass.
         S_TL: begin
            we = 1'b1; wa = lim_ff[IW-1:0]; wd = hold_ff;
            lim_in = lim_ff - 1'b1; st_in = S_SRD;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; cnt_ff <= '0; o_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; o_v_ff <= o_v_in;
      end
      c_ff <= c_in; i_ff <= i_in; j_ff <= j_in; lim_ff <= lim_in;
      hit_ff <= hit_in; hold_ff <= hold_in; pend_ff <= pend_in;
      pend_rec_ff <= pend_rec_in; o_ff <= o_in;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(rtss_pkg::Depth)) else $error("count beyond depth");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !back_ready) else $error("ready while working");
   a_last: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && o_ff.status != rtss_pkg::ST_RECORD |-> o_ff.last)
      else $error("status not last");
endmodule
`default_nettype wire

// ===== hw/rtl/record_table_sort_search.sv =====
// Record table with insert, search, update, delete, list and stable bubble sort.
// Insert appends the record; search, update, delete and list walk all stored
// records; sort runs bubble passes, each one record shorter. One command
// runs at a time in the back end, the 2-entry command queue hides the front.
// Results cannot be stalled. Synchronous reset empties the table and queue.
`timescale 1ns / 1ps
`default_nettype none
module record_table_sort_search (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire rtss_pkg::req_type req_data,
   output logic busy,
   output logic rsp_strobe,
   output rtss_pkg::rsp_type rsp_data
);
   rtss_pkg::cmd_type cmd;
   rtss_pkg::qctl_type qctl;
   logic back_ready;

   rtss_front u_front (.clock, .reset, .start, .req_data, .busy, .cmd,
      .qctl_out(qctl), .back_ready);
   rtss_back u_back (.clock, .reset, .cmd, .qctl_in(qctl), .back_ready,
      .rsp_strobe, .rsp_data);
endmodule
`default_nettype wire
